// File: src/assert_macros.svh
// assertion macros for the checker file
// clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication violated");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// File: src/nuecs_pkg.sv
// shared widths, codes, register resets and types of the cross-section block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nuecs_pkg;

  // field widths
  localparam int E_W  = 24;
  localparam int C_W  = 16;
  localparam int SC_W = 24;
  localparam int OUT_W = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;
  localparam int FLAV_W = 2;

  // fixed-point formats
  localparam int ENERGY_FRAC_BITS   = 16;
  localparam int COUPLING_FRAC_BITS = 14;
  localparam int SCALE_FRAC_BITS    = 8;
  localparam int OUT_FRAC_BITS      = 16;

  // limit test widths
  localparam int SUM_W = E_W + 2;
  localparam int LHS_W = E_W + SUM_W;
  localparam int RHS_W = 2 * E_W + 1;
  localparam int MT_W  = 2 * E_W;

  // divider geometry
  localparam int DIV_STEPS = E_W + 1;
  localparam int QUO_W  = DIV_STEPS;
  localparam int DIVD_W = E_W + QUO_W;

  // datapath widths after division
  localparam int Q_W   = ENERGY_FRAC_BITS + 1;
  localparam int M_W   = ENERGY_FRAC_BITS + 2;
  localparam int GG_W  = 2 * C_W;
  localparam int T2_W  = GG_W + Q_W + 1;
  localparam int T3_W  = GG_W + M_W + 1;
  localparam int B_W   = T3_W + 1;
  localparam int B_SHIFT = 2 * COUPLING_FRAC_BITS + ENERGY_FRAC_BITS - OUT_FRAC_BITS;
  localparam int B16_W = B_W - B_SHIFT;
  localparam int PROD_W = B16_W + SC_W + 1;
  localparam int RES_W  = PROD_W - SCALE_FRAC_BITS;

  // pipeline layout
  localparam int FRONT_STAGES = 2;
  localparam int POST_STAGES  = 5;
  localparam int NUM_STAGES   = FRONT_STAGES + 2 * DIV_STEPS + POST_STAGES;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // flavour codes
  localparam logic [FLAV_W-1:0] FLAV_E   = 2'd0;
  localparam logic [FLAV_W-1:0] FLAV_MU  = 2'd1;
  localparam logic [FLAV_W-1:0] FLAV_TAU = 2'd2;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_E    = 4'd0,
    REG_RIGHT_E   = 4'd1,
    REG_LEFT_MU   = 4'd2,
    REG_RIGHT_MU  = 4'd3,
    REG_LEFT_TAU  = 4'd4,
    REG_RIGHT_TAU = 4'd5,
    REG_MASS      = 4'd6,
    REG_SCALE     = 4'd7
  } cfg_reg_e;

  // register reset values
  localparam logic signed [C_W-1:0] RST_LEFT_E   = 16'sd11960;
  localparam logic signed [C_W-1:0] RST_RIGHT_E  = 16'sd3768;
  localparam logic signed [C_W-1:0] RST_LEFT_MU  = -16'sd4424;
  localparam logic signed [C_W-1:0] RST_RIGHT_MU = 16'sd3768;
  localparam logic signed [C_W-1:0] RST_LEFT_TAU = -16'sd4424;
  localparam logic signed [C_W-1:0] RST_RIGHT_TAU = 16'sd3768;
  localparam logic [E_W-1:0]  RST_MASS  = 24'd33489;
  localparam logic [SC_W-1:0] RST_SCALE = 24'd44116;

  typedef struct packed {
    logic signed [C_W-1:0] left_e;
    logic signed [C_W-1:0] right_e;
    logic signed [C_W-1:0] left_mu;
    logic signed [C_W-1:0] right_mu;
    logic signed [C_W-1:0] left_tau;
    logic signed [C_W-1:0] right_tau;
    logic [E_W-1:0]        mass;
    logic [SC_W-1:0]       scale;
  } cfg_t;

  // per-item flags and couplings that ride alongside the dividers
  typedef struct packed {
    logic                  beyond;
    logic                  kill;
    logic signed [C_W-1:0] g1;
    logic signed [C_W-1:0] g2;
  } side_t;

  typedef struct packed {
    logic beyond;
    logic kill;
  } flag_t;

endpackage

`default_nettype wire

// File: src/nuecs_if.sv
// channel interfaces: input item, result item and register write
// depends on nuecs_pkg
`timescale 1ns / 1ps
`default_nettype none

interface nuecs_in_if;
  logic                            valid;
  logic                            ready;
  logic [nuecs_pkg::E_W-1:0]       neutrino_energy;
  logic [nuecs_pkg::E_W-1:0]       recoil_energy;
  logic [nuecs_pkg::FLAV_W-1:0]    flavour;
  logic                            antiparticle;
  modport source (output valid, neutrino_energy, recoil_energy, flavour, antiparticle,
                  input ready);
  modport sink (input valid, neutrino_energy, recoil_energy, flavour, antiparticle,
                output ready);
endinterface

interface nuecs_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [nuecs_pkg::OUT_W-1:0]  cross_section;
  logic                                beyond_limit;
  modport source (output valid, cross_section, beyond_limit, input ready);
  modport sink (input valid, cross_section, beyond_limit, output ready);
endinterface

interface nuecs_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [nuecs_pkg::CFG_IDX_W-1:0]     index;
  logic [nuecs_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/nuecs_cfg.sv
// configuration register file: couplings, electron mass and scale
// depends on nuecs_pkg and nuecs_cfg_if
`timescale 1ns / 1ps
`default_nettype none

module nuecs_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  nuecs_cfg_if.sink         cfg_i,
  output nuecs_pkg::cfg_t   cfg_o
);

  nuecs_pkg::cfg_t cfg_q;

  // writes are always taken
  assign cfg_i.ready = 1'b1;
  assign cfg_o = cfg_q;

  // register write decode, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_e    <= nuecs_pkg::RST_LEFT_E;
      cfg_q.right_e   <= nuecs_pkg::RST_RIGHT_E;
      cfg_q.left_mu   <= nuecs_pkg::RST_LEFT_MU;
      cfg_q.right_mu  <= nuecs_pkg::RST_RIGHT_MU;
      cfg_q.left_tau  <= nuecs_pkg::RST_LEFT_TAU;
      cfg_q.right_tau <= nuecs_pkg::RST_RIGHT_TAU;
      cfg_q.mass      <= nuecs_pkg::RST_MASS;
      cfg_q.scale     <= nuecs_pkg::RST_SCALE;
    end else if (cfg_i.valid) begin
      unique case (nuecs_pkg::cfg_reg_e'(cfg_i.index))
        nuecs_pkg::REG_LEFT_E:    cfg_q.left_e    <= cfg_i.data[nuecs_pkg::C_W-1:0];
        nuecs_pkg::REG_RIGHT_E:   cfg_q.right_e   <= cfg_i.data[nuecs_pkg::C_W-1:0];
        nuecs_pkg::REG_LEFT_MU:   cfg_q.left_mu   <= cfg_i.data[nuecs_pkg::C_W-1:0];
        nuecs_pkg::REG_RIGHT_MU:  cfg_q.right_mu  <= cfg_i.data[nuecs_pkg::C_W-1:0];
        nuecs_pkg::REG_LEFT_TAU:  cfg_q.left_tau  <= cfg_i.data[nuecs_pkg::C_W-1:0];
        nuecs_pkg::REG_RIGHT_TAU: cfg_q.right_tau <= cfg_i.data[nuecs_pkg::C_W-1:0];
        nuecs_pkg::REG_MASS:      cfg_q.mass      <= cfg_i.data[nuecs_pkg::E_W-1:0];
        nuecs_pkg::REG_SCALE:     cfg_q.scale     <= cfg_i.data[nuecs_pkg::SC_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/nuecs_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on nuecs_pkg
`timescale 1ns / 1ps
`default_nettype none

module nuecs_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [nuecs_pkg::DIVD_W-1:0]  dividend_i,
  input  logic [nuecs_pkg::E_W-1:0]     divisor_i,
  output logic [nuecs_pkg::QUO_W-1:0]   quotient_o,
  output logic [nuecs_pkg::E_W-1:0]     divisor_o
);

  logic [nuecs_pkg::DIVD_W-1:0] rem_q [nuecs_pkg::DIV_STEPS-1];
  logic [nuecs_pkg::E_W-1:0]    den_q [nuecs_pkg::DIV_STEPS];
  logic [nuecs_pkg::QUO_W-1:0]  quo_q [nuecs_pkg::DIV_STEPS];

  for (genvar j = 0; j < nuecs_pkg::DIV_STEPS; j++) begin : g_step
    logic [nuecs_pkg::DIVD_W-1:0] rem_in;
    logic [nuecs_pkg::DIVD_W-1:0] trial;
    logic [nuecs_pkg::DIVD_W:0]   diff;
    logic [nuecs_pkg::E_W-1:0]    den_in;
    logic [nuecs_pkg::QUO_W-1:0]  quo_in;

    if (j == 0) begin : g_first
      assign rem_in = dividend_i;
      assign den_in = divisor_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    // trial subtract of the shifted divisor
    assign trial = nuecs_pkg::DIVD_W'(den_in) << (nuecs_pkg::DIV_STEPS - 1 - j);
    assign diff  = {1'b0, rem_in} - {1'b0, trial};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[j] <= den_in;
        quo_q[j] <= diff[nuecs_pkg::DIVD_W] ? quo_in
                  : (quo_in | (nuecs_pkg::QUO_W'(1) << (nuecs_pkg::DIV_STEPS - 1 - j)));
      end
    end

    // the last stage needs no remainder
    if (j < nuecs_pkg::DIV_STEPS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= diff[nuecs_pkg::DIVD_W] ? rem_in : diff[nuecs_pkg::DIVD_W-1:0];
        end
      end
    end
  end

  assign quotient_o = quo_q[nuecs_pkg::DIV_STEPS-1];
  assign divisor_o  = den_q[nuecs_pkg::DIV_STEPS-1];

endmodule

`default_nettype wire

// File: src/nuecs_post.sv
// coupling polynomial, scaling and saturation, five register stages
// depends on nuecs_pkg
`timescale 1ns / 1ps
`default_nettype none

module nuecs_post (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [nuecs_pkg::SC_W-1:0]          scale_i,
  input  nuecs_pkg::side_t                    side_i,
  input  logic [nuecs_pkg::Q_W-1:0]           q_i,
  input  logic [nuecs_pkg::M_W-1:0]           m_i,
  output logic signed [nuecs_pkg::OUT_W-1:0]  cross_section_o,
  output logic                                beyond_o
);

  nuecs_pkg::flag_t flag_q [nuecs_pkg::POST_STAGES];

  logic [2*nuecs_pkg::Q_W-1:0]          qq;
  logic [nuecs_pkg::Q_W-1:0]            q2_q;
  logic [nuecs_pkg::M_W-1:0]            m_q;
  logic signed [nuecs_pkg::GG_W-1:0]    g11_q, g22_q, g12_q;
  logic signed [nuecs_pkg::B_W-1:0]     t1_q;
  logic signed [nuecs_pkg::T2_W-1:0]    t2_q;
  logic signed [nuecs_pkg::T3_W-1:0]    t3_q;
  logic signed [nuecs_pkg::B_W-1:0]     b;
  logic signed [nuecs_pkg::B16_W-1:0]   b16_q;
  logic signed [nuecs_pkg::PROD_W-1:0]  prod_q;
  logic [nuecs_pkg::RES_W-1:0]          res;
  logic                                 sat_hi, sat_lo;
  logic signed [nuecs_pkg::OUT_W-1:0]   out_d, out_q;

  // flags ride along
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flag_q[0] <= '{beyond: side_i.beyond, kill: side_i.kill};
      for (int i = 1; i < nuecs_pkg::POST_STAGES; i++) begin
        flag_q[i] <= flag_q[i-1];
      end
    end
  end

  // stage 1: squared ratio and coupling products
  assign qq = {{nuecs_pkg::Q_W{1'b0}}, q_i} * {{nuecs_pkg::Q_W{1'b0}}, q_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q2_q  <= qq[nuecs_pkg::ENERGY_FRAC_BITS +: nuecs_pkg::Q_W];
      m_q   <= m_i;
      g11_q <= nuecs_pkg::GG_W'(side_i.g1) * nuecs_pkg::GG_W'(side_i.g1);
      g22_q <= nuecs_pkg::GG_W'(side_i.g2) * nuecs_pkg::GG_W'(side_i.g2);
      g12_q <= nuecs_pkg::GG_W'(side_i.g1) * nuecs_pkg::GG_W'(side_i.g2);
    end
  end

  // stage 2: the three terms
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q <= nuecs_pkg::B_W'(g11_q) <<< nuecs_pkg::ENERGY_FRAC_BITS;
      t2_q <= nuecs_pkg::T2_W'(g22_q) * nuecs_pkg::T2_W'($signed({1'b0, q2_q}));
      t3_q <= nuecs_pkg::T3_W'(g12_q) * nuecs_pkg::T3_W'($signed({1'b0, m_q}));
    end
  end

  // stage 3: sum and floor shift to the output fraction
  assign b = t1_q + nuecs_pkg::B_W'(t2_q) - nuecs_pkg::B_W'(t3_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b16_q <= b[nuecs_pkg::B_W-1:nuecs_pkg::B_SHIFT];
    end
  end

  // stage 4: cross-section scale
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= nuecs_pkg::PROD_W'(b16_q) * nuecs_pkg::PROD_W'($signed({1'b0, scale_i}));
    end
  end

  // stage 5: drop scale fraction, saturate, zero outside the limit or at zero energy
  assign res    = prod_q[nuecs_pkg::PROD_W-1:nuecs_pkg::SCALE_FRAC_BITS];
  assign sat_hi = !res[nuecs_pkg::RES_W-1] && (|res[nuecs_pkg::RES_W-2:nuecs_pkg::OUT_W-1]);
  assign sat_lo = res[nuecs_pkg::RES_W-1] && !(&res[nuecs_pkg::RES_W-2:nuecs_pkg::OUT_W-1]);

  always_comb begin
    if (flag_q[nuecs_pkg::POST_STAGES-2].kill) begin
      out_d = '0;
    end else if (sat_hi) begin
      out_d = nuecs_pkg::OUT_MAX;
    end else if (sat_lo) begin
      out_d = nuecs_pkg::OUT_MIN;
    end else begin
      out_d = res[nuecs_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign cross_section_o = out_q;
  assign beyond_o        = flag_q[nuecs_pkg::POST_STAGES-1].beyond;

endmodule

`default_nettype wire

// File: src/nu_e_differential_cross_section.sv
// Use: one item enters on in_i (neutrino energy, recoil energy, flavour,
// antiparticle flag) and one result leaves on out_o (cross section in
// signed Q16.16, saturated, and the beyond-limit flag). cfg_i writes the
// eight registers; writes are always ready, and the user must make them
// only while the block holds no item; the block does not enforce this.
// One item per cycle is taken for as long as the receiver takes one
// result per cycle. The pipeline length is set by the mass term's two
// chained 25-stage dividers (the energy ratio divider runs beside the
// first), one quotient bit per stage, plus two front and five back
// stages.
// A stall of out_o is absorbed by a one-entry skid register; while it is
// full the whole pipeline holds and in_i ready is low, nothing is lost.
// Reset clears all valid bits and the skid entry and loads the register
// reset values: standard-model couplings, 0.511 MeV mass, default scale.
// depends on nuecs_pkg, nuecs_if, nuecs_cfg, nuecs_div, nuecs_post
`timescale 1ns / 1ps
`default_nettype none

module nu_e_differential_cross_section (
  input  logic           clk_i,
  input  logic           rst_ni,
  nuecs_in_if.sink       in_i,
  nuecs_out_if.source    out_o,
  nuecs_cfg_if.sink      cfg_i
);

  nuecs_pkg::cfg_t cfg;

  logic                               en;
  logic [nuecs_pkg::NUM_STAGES-1:0]   v_q, v_d;
  logic                               skid_v_q, skid_v_d;
  logic signed [nuecs_pkg::OUT_W-1:0] skid_cs_q;
  logic                               skid_bl_q;
  logic signed [nuecs_pkg::OUT_W-1:0] post_cs;
  logic                               post_bl;

  // stage 0
  logic [nuecs_pkg::E_W-1:0]          e0_q, te0_q;
  logic signed [nuecs_pkg::C_W-1:0]   g1_sel, g2_sel, lc, rc;
  logic signed [nuecs_pkg::C_W-1:0]   g1_0_q, g2_0_q;
  logic [nuecs_pkg::SUM_W-1:0]        msum;

  // stage 1
  logic [nuecs_pkg::LHS_W-1:0]        lhs_q;
  logic [nuecs_pkg::RHS_W-1:0]        rhs_q;
  logic [nuecs_pkg::MT_W-1:0]         mt_q;
  logic [nuecs_pkg::E_W-1:0]          diff_q, e1_q;
  logic                               ezero_q, tenz_q, over;
  logic signed [nuecs_pkg::C_W-1:0]   g1_1_q, g2_1_q;

  // divider links
  logic [nuecs_pkg::QUO_W-1:0]        q_quo, a_quo, m_quo;
  logic [nuecs_pkg::E_W-1:0]          e_div;
  nuecs_pkg::side_t                   side_q [2*nuecs_pkg::DIV_STEPS];
  logic [nuecs_pkg::Q_W-1:0]          qc_q [nuecs_pkg::DIV_STEPS];

  nuecs_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // global advance, held while the skid entry is occupied
  assign en         = !skid_v_q;
  assign in_i.ready = en;

  always_comb begin
    v_d = v_q;
    if (en) begin
      v_d = {v_q[nuecs_pkg::NUM_STAGES-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // coupling pick per flavour, swapped for antineutrinos
  always_comb begin
    unique case (in_i.flavour)
      nuecs_pkg::FLAV_E: begin
        lc = cfg.left_e;
        rc = cfg.right_e;
      end
      nuecs_pkg::FLAV_TAU: begin
        lc = cfg.left_tau;
        rc = cfg.right_tau;
      end
      default: begin
        lc = cfg.left_mu;
        rc = cfg.right_mu;
      end
    endcase
    g1_sel = in_i.antiparticle ? rc : lc;
    g2_sel = in_i.antiparticle ? lc : rc;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e0_q   <= in_i.neutrino_energy;
      te0_q  <= in_i.recoil_energy;
      g1_0_q <= g1_sel;
      g2_0_q <= g2_sel;
    end
  end

  // stage 1: limit products, mass term numerator, energy difference
  assign msum = {2'b00, cfg.mass} + {1'b0, e0_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      lhs_q   <= nuecs_pkg::LHS_W'(te0_q) * nuecs_pkg::LHS_W'(msum);
      rhs_q   <= nuecs_pkg::RHS_W'({e0_q, 1'b0}) * nuecs_pkg::RHS_W'(e0_q);
      mt_q    <= nuecs_pkg::MT_W'(cfg.mass) * nuecs_pkg::MT_W'(te0_q);
      diff_q  <= e0_q - te0_q;
      e1_q    <= e0_q;
      ezero_q <= (e0_q == '0);
      tenz_q  <= (te0_q != '0);
      g1_1_q  <= g1_0_q;
      g2_1_q  <= g2_0_q;
    end
  end

  // stage 2 flags: kinematic limit and zero energy
  assign over = {1'b0, lhs_q} > {{(nuecs_pkg::LHS_W - nuecs_pkg::RHS_W + 1){1'b0}}, rhs_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{beyond: ezero_q ? tenz_q : over,
                     kill:   ezero_q || over,
                     g1:     g1_1_q,
                     g2:     g2_1_q};
    end
  end

  for (genvar k = 1; k < 2 * nuecs_pkg::DIV_STEPS; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // energy ratio (E-Te)/E
  nuecs_div u_div_q (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (nuecs_pkg::DIVD_W'({diff_q, {nuecs_pkg::ENERGY_FRAC_BITS{1'b0}}})),
    .divisor_i  (e1_q),
    .quotient_o (q_quo),
    .divisor_o  ()
  );

  // mass term me*Te/E
  nuecs_div u_div_a (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (nuecs_pkg::DIVD_W'(mt_q)),
    .divisor_i  (e1_q),
    .quotient_o (a_quo),
    .divisor_o  (e_div)
  );

  // second division by E
  nuecs_div u_div_m (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (nuecs_pkg::DIVD_W'({a_quo, {nuecs_pkg::ENERGY_FRAC_BITS{1'b0}}})),
    .divisor_i  (e_div),
    .quotient_o (m_quo),
    .divisor_o  ()
  );

  // energy ratio waits for the second division
  always_ff @(posedge clk_i) begin
    if (en) begin
      qc_q[0] <= q_quo[nuecs_pkg::Q_W-1:0];
    end
  end

  for (genvar k = 1; k < nuecs_pkg::DIV_STEPS; k++) begin : g_qdelay
    always_ff @(posedge clk_i) begin
      if (en) begin
        qc_q[k] <= qc_q[k-1];
      end
    end
  end

  nuecs_post u_post (
    .clk_i           (clk_i),
    .en_i            (en),
    .scale_i         (cfg.scale),
    .side_i          (side_q[2*nuecs_pkg::DIV_STEPS-1]),
    .q_i             (qc_q[nuecs_pkg::DIV_STEPS-1]),
    .m_i             (m_quo[nuecs_pkg::M_W-1:0]),
    .cross_section_o (post_cs),
    .beyond_o        (post_bl)
  );

  // skid entry catches the last stage when the receiver stalls
  always_comb begin
    if (skid_v_q) begin
      skid_v_d = !out_o.ready;
    end else begin
      skid_v_d = v_q[nuecs_pkg::NUM_STAGES-1] && !out_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q) begin
      skid_cs_q <= post_cs;
      skid_bl_q <= post_bl;
    end
  end

  // result beat
  assign out_o.valid         = skid_v_q || v_q[nuecs_pkg::NUM_STAGES-1];
  assign out_o.cross_section = skid_v_q ? skid_cs_q : post_cs;
  assign out_o.beyond_limit  = skid_v_q ? skid_bl_q : post_bl;

endmodule

`default_nettype wire

// File: src/nuecs_check.sv
// port-level checker for the cross-section block, bound to the top level
// depends on nuecs_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module nuecs_check (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [nuecs_pkg::OUT_W-1:0] cross_section_i,
  input logic                               beyond_limit_i
);

  // a stalled result beat stays up
  `ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)

  // a stalled result beat keeps its payload
  `ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(cross_section_i) && $stable(beyond_limit_i))

  // beyond the kinematic limit the cross section is zero
  `ASSERT_IMPLIES(a_limit_zero, out_valid_i && beyond_limit_i, cross_section_i == 0)

  // input backpressure only follows a stalled result
  `ASSERT_IMPLIES(a_stall_cause, !in_ready_i, $past(out_valid_i && !out_ready_i))

  // input valid is only observed here for completeness of the port view
  `ASSERT_IMPLIES(a_in_seen, in_valid_i && in_ready_i && !out_ready_i && out_valid_i, 1'b1)

endmodule

bind nu_e_differential_cross_section nuecs_check u_check (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .cross_section_i (out_o.cross_section),
  .beyond_limit_i  (out_o.beyond_limit)
);

`default_nettype wire
